// File: rtl/core/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types, codes and double-dabble helpers for the decimal ASCII
// formatter.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int unsigned BinW  = 32;
  localparam int unsigned NDig  = 10;
  localparam int unsigned BcdW  = 4 * NDig;
  localparam int unsigned DdW   = BcdW + BinW;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NDdStage = BinW / StepsPerStage;

  localparam logic [1:0] MODE_U32 = 2'd0;
  localparam logic [1:0] MODE_U16 = 2'd1;
  localparam logic [1:0] MODE_S16 = 2'd2;
  localparam logic [1:0] MODE_S32 = 2'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  localparam logic [3:0] POS_DIG10 = 4'd9;
  localparam logic [3:0] POS_DIG5  = 4'd4;

  typedef logic [DdW-1:0] dd_t;
  typedef logic [NDig-1:0][3:0] bcd_t;

  function automatic dd_t dd_one(input dd_t x);
    dd_t y;
    y = x;
    for (int d = 0; d < NDig; d++) begin
      if (y[BinW + 4*d +: 4] >= 4'd5) begin
        y[BinW + 4*d +: 4] = y[BinW + 4*d +: 4] + 4'd3;
      end
    end
    return {y[DdW-2:0], 1'b0};
  endfunction

  function automatic dd_t dd_stage(input dd_t x);
    dd_t y;
    y = x;
    for (int s = 0; s < StepsPerStage; s++) begin
      y = dd_one(y);
    end
    return y;
  endfunction

endpackage

// File: rtl/core/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Formats a 32-bit value as fixed-width zero-padded decimal ASCII characters.
// ----------------------------------------------------------------------------
// Input channel: in_value and in_mode, one number per beat (in_valid/in_stall).
// Mode 0 gives 10 digits, mode 1 gives 5 digits of the low half, mode 2 gives
// a sign character and 5 digits, mode 3 a sign character and 10 digits.
// Output channel: one ASCII character per beat, most significant first,
// out_last high on the final digit of each number.
// The first character of a number is offered from the output register once
// the number has passed through the sign/magnitude stage and then four
// double-dabble stages of eight shifts each.
// Pacing: the output register sends one character per beat, 10, 5, 6 or 11
// characters per number for modes 0..3; the five pipeline stages take a new
// number every cycle until all of them hold one, then advance one number
// each time the serializer sends its last character.
// Reset clears all valid bits; nothing is kept between numbers.
// A stall on the output holds the current character; full stages back up
// into in_stall without losing or repeating any beat.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii
  import ida_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);

  localparam int unsigned NStg = NDdStage + 1;

  logic [NStg-1:0] vld_r;
  dd_t             dd_r   [NStg];
  logic [1:0]      mode_r [NStg];
  logic            neg_r  [NStg];
  logic [NStg:0]   adv;

  logic        ser_vld_r, ser_vld_nxt;
  bcd_t        dig_r;
  logic [3:0]  pos_r, pos_nxt;
  logic        sgn_pend_r, sgn_pend_nxt;
  logic        neg_out_r;
  logic        out_take;
  logic        ser_load;

  logic        in_neg;
  logic [31:0] in_mag;

  always_comb begin
    in_neg = 1'b0;
    in_mag = in_value;
    case (in_mode)
      MODE_U32: begin
        in_mag = in_value;
      end
      MODE_U16: begin
        in_mag = {16'd0, in_value[15:0]};
      end
      MODE_S16: begin
        in_neg = in_value[15];
        in_mag = in_value[15] ? {16'd0, 16'd0 - in_value[15:0]} : {16'd0, in_value[15:0]};
      end
      MODE_S32: begin
        in_neg = in_value[31];
        in_mag = in_value[31] ? 32'd0 - in_value : in_value;
      end
      default: begin
        in_mag = in_value;
      end
    endcase
  end

  assign out_take = ser_vld_r && !out_stall;
  assign out_last = !sgn_pend_r && (pos_r == '0);
  assign ser_load = !ser_vld_r || (out_take && out_last);

  always_comb begin
    adv[NStg] = ser_load;
    for (int k = NStg - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dd_r[0]   <= {{BcdW{1'b0}}, in_mag};
      mode_r[0] <= in_mode;
      neg_r[0]  <= in_neg;
    end
    for (int k = 1; k < NStg; k++) begin
      if (adv[k]) begin
        dd_r[k]   <= dd_stage(dd_r[k-1]);
        mode_r[k] <= mode_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
    end
  end

  always_comb begin
    ser_vld_nxt  = ser_vld_r;
    pos_nxt      = pos_r;
    sgn_pend_nxt = sgn_pend_r;
    if (ser_load) begin
      ser_vld_nxt  = vld_r[NStg-1];
      sgn_pend_nxt = mode_r[NStg-1][1];
      pos_nxt      = (mode_r[NStg-1] inside {MODE_U16, MODE_S16}) ? POS_DIG5 : POS_DIG10;
    end else if (out_take) begin
      if (sgn_pend_r) begin
        sgn_pend_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
    end else begin
      ser_vld_r <= ser_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    sgn_pend_r <= sgn_pend_nxt;
    if (ser_load) begin
      dig_r     <= dd_r[NStg-1][DdW-1 -: BcdW];
      neg_out_r <= neg_r[NStg-1];
    end
  end

  always_comb begin
    if (sgn_pend_r) begin
      out_character = neg_out_r ? ASCII_MINUS : ASCII_SPACE;
    end else begin
      out_character = ASCII_ZERO + {4'd0, dig_r[pos_r]};
    end
  end

  assign out_valid = ser_vld_r;

endmodule

// File: bench/decimal_text_checker.sv
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both channels of integer_to_decimal_ascii. Each number accepted on
// the input is turned into its expected decimal text, and each character that
// leaves the block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module decimal_text_checker
  import ida_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_mode,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_character,
  input  logic        out_last,
  output int unsigned fail_count,
  output int unsigned chars_pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_beat_t;

  text_beat_t expected_text[$];

  initial begin
    fail_count    = 0;
    chars_pending = 0;
  end

  function automatic void format_decimal(input logic [31:0] value, input logic [1:0] mode);
    logic [31:0] mag;
    logic [31:0] weight;
    logic [31:0] digit;
    logic [15:0] low;
    logic        neg;
    logic        signed_mode;
    int          ndig;
    text_beat_t  beat;
    low         = value[15:0];
    neg         = 1'b0;
    signed_mode = 1'b0;
    case (mode)
      MODE_U32: begin
        mag  = value;
        ndig = 10;
      end
      MODE_U16: begin
        mag  = {16'd0, low};
        ndig = 5;
      end
      MODE_S16: begin
        signed_mode = 1'b1;
        neg  = low[15];
        mag  = neg ? {16'd0, 16'd0 - low} : {16'd0, low};
        ndig = 5;
      end
      default: begin
        signed_mode = 1'b1;
        neg  = value[31];
        mag  = neg ? 32'd0 - value : value;
        ndig = 10;
      end
    endcase
    if (signed_mode) begin
      beat.code = neg ? ASCII_MINUS : ASCII_SPACE;
      beat.last = 1'b0;
      expected_text.push_back(beat);
    end
    weight = (ndig == 10) ? 32'd1000000000 : 32'd10000;
    for (int i = 0; i < ndig; i++) begin
      digit     = mag / weight;
      mag       = mag - digit * weight;
      beat.code = ASCII_ZERO + digit[7:0];
      beat.last = (i == ndig - 1);
      expected_text.push_back(beat);
      weight    = weight / 10;
    end
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        format_decimal(in_value, in_mode);
      end
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $error("unexpected beat: character %h last %b", out_character, out_last);
          fail_count = fail_count + 1;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.code) begin
            $error("character: expected %h, got %h", want.code, out_character);
            fail_count = fail_count + 1;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    chars_pending = expected_text.size();
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for integer_to_decimal_ascii. Drives directed boundary
// numbers in every mode, then random numbers under random idling, a long
// output hold-off and a stretch with no idling; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;
  import ida_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [31:0] in_value  = 32'd0;
  logic [1:0]  in_mode   = MODE_U32;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_character;
  logic        out_last;

  int unsigned fail_count;
  int unsigned chars_pending;
  int unsigned gap_pct   = 9;
  int unsigned stall_pct = 9;
  bit          hold_req  = 1'b0;

  integer_to_decimal_ascii uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  decimal_text_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (hold_left = 120; hold_left > 0; hold_left--) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(20);
      2: v = $urandom >> $urandom_range(31);
      default: v = ($urandom_range(1) ? 32'h8000_0000 : 32'h0000_8000)
                   + $urandom_range(4) - 32'd2;
    endcase
    return v;
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat.
  task automatic send_number(input logic [31:0] value, input logic [1:0] mode);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_mode  <= mode;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_number(pick_value(), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_number(32'd0,          MODE_U32);
    send_number(32'hFFFF_FFFF,  MODE_U32);
    send_number(32'd1000000000, MODE_U32);
    send_number(32'd999999999,  MODE_U32);
    send_number(32'd0,          MODE_U16);
    send_number(32'h0000_FFFF,  MODE_U16);
    send_number(32'hFFFF_0000,  MODE_U16);
    send_number(32'd12345,      MODE_U16);
    send_number(32'h0000_8000,  MODE_S16);
    send_number(32'h0000_7FFF,  MODE_S16);
    send_number(32'h0000_FFFF,  MODE_S16);
    send_number(32'd0,          MODE_S16);
    send_number(32'hABCD_8001,  MODE_S16);
    send_number(32'h8000_0000,  MODE_S32);
    send_number(32'h7FFF_FFFF,  MODE_S32);
    send_number(32'hFFFF_FFFF,  MODE_S32);
    send_number(32'd0,          MODE_S32);
    send_number(32'd1,          MODE_S32);

    // Drain fully before the hold-off.
    in_valid <= 1'b0;
    wait (chars_pending == 0);
    @(negedge clk);

    hold_req = 1'b1;
    send_random(20);

    gap_pct   = 0;
    stall_pct = 0;
    send_random(40);
    gap_pct   = 9;
    stall_pct = 9;

    send_random(95);

    in_valid <= 1'b0;
    wait (chars_pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ida_pkg.sv
rtl/core/integer_to_decimal_ascii.sv
bench/decimal_text_checker.sv
bench/tb_top.sv
